// ----- design/bol_pkg.sv -----
`timescale 1ns / 1ps

package bol_pkg;

	localparam int CAPACITY = 16;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OFS_W = CNT_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);
	localparam int QF_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ_OUT   = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH_BACK,
		OP_PUSH_FRONT,
		OP_REMOVE,
		OP_READ_OUT
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_MATCH = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SHIFT,
		BK_READ,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [WORD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_t;

	// physical slot of a logical position in the circular store
	function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
			input logic [OFS_W-1:0] ofs);
		logic [OFS_W-1:0] s;
		s = OFS_W'(head) + ofs;
		if (s >= OFS_W'(CAPACITY)) begin
			s = s - OFS_W'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == '0) begin
			r = IDX_W'(CAPACITY - 1);
		end else begin
			r = p - IDX_W'(1);
		end
		return r;
	endfunction

	function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[OCC_W-1:0];
	endfunction

endpackage

// ----- design/bol_req_if.sv -----
`timescale 1ns / 1ps

interface bol_req_if;
	import bol_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink (input valid, kind, value, output ready);

endinterface

// ----- design/bol_rsp_if.sv -----
`timescale 1ns / 1ps

interface bol_rsp_if;
	import bol_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] element;
	logic                     last;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, status, element, last, occupancy, input ready);
	modport sink (input valid, status, element, last, occupancy, output ready);

endinterface

// ----- design/bol_front.sv -----
`timescale 1ns / 1ps

module bol_front (
	input  logic            clk,
	input  logic            arst_n,
	bol_req_if.sink         req,
	output bol_pkg::queue_t q,
	input  logic            pop
);
	import bol_pkg::*;

	item_t             fifo_q [QUEUE_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QF_W-1:0]   fill_q;
	logic              push;
	logic              do_pop;
	item_t             new_item;

	always_comb begin
		new_item.value = req.value;
		case (req.kind)
			KIND_PUSH_BACK:  new_item.op = OP_PUSH_BACK;
			KIND_PUSH_FRONT: new_item.op = OP_PUSH_FRONT;
			KIND_REMOVE:     new_item.op = OP_REMOVE;
			KIND_READ_OUT:   new_item.op = OP_READ_OUT;
			default:         new_item.op = OP_READ_OUT;
		endcase
	end

	assign req.ready = (fill_q != QF_W'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign do_pop    = pop && (fill_q != '0);

	assign q.valid = (fill_q != '0);
	assign q.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + QF_W'(1);
			end else if (do_pop && !push) begin
				fill_q <= fill_q - QF_W'(1);
			end
		end
	end

endmodule

// ----- design/bol_back.sv -----
`timescale 1ns / 1ps

module bol_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bol_pkg::queue_t q,
	output logic            pop,
	bol_rsp_if.source       rsp
);
	import bol_pkg::*;

	logic signed [WORD_W-1:0] mem [CAPACITY];
	logic signed [WORD_W-1:0] rdata_q;

	back_state_t              state_q, state_d;
	logic [IDX_W-1:0]         head_q, head_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [IDX_W-1:0]         idx_q, idx_d;
	logic signed [WORD_W-1:0] val_q;
	status_t                  fin_status_q;
	logic                     fin_dec_q;

	logic                     fin_load;
	status_t                  fin_status;
	logic                     fin_dec;

	logic                     mem_we;
	logic [IDX_W-1:0]         mem_waddr;
	logic signed [WORD_W-1:0] mem_wdata;
	logic [IDX_W-1:0]         mem_raddr;

	logic                     emit;
	status_t                  e_status;
	logic signed [WORD_W-1:0] e_element;
	logic                     e_last;

	logic                     rsp_valid_q;
	status_t                  rsp_status_q;
	logic signed [WORD_W-1:0] rsp_element_q;
	logic                     rsp_last_q;
	logic [OCC_W-1:0]         rsp_occ_q;

	logic                     out_free;
	logic                     full;
	logic                     empty;
	logic                     idx_last;
	logic                     shift_last;
	logic                     hit;

	assign out_free   = !rsp_valid_q || rsp.ready;
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign empty      = (count_q == '0);
	assign idx_last   = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
	assign shift_last = (CNT_W'(idx_q) + CNT_W'(2) == count_q);
	assign hit        = (rdata_q == val_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q.valid && out_free) begin
					if (q.item.op == OP_REMOVE && !empty) begin
						state_d = BK_SCAN;
					end else if (q.item.op == OP_READ_OUT && !empty) begin
						state_d = BK_READ;
					end
				end
			end
			BK_SCAN: begin
				if (hit && !idx_last) begin
					state_d = BK_SHIFT;
				end else if (idx_last) begin
					state_d = BK_FIN;
				end
			end
			BK_SHIFT: begin
				if (shift_last) begin
					state_d = BK_FIN;
				end
			end
			BK_READ: begin
				if (out_free && idx_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		pop        = 1'b0;
		head_d     = head_q;
		count_d    = count_q;
		idx_d      = idx_q;
		fin_load   = 1'b0;
		fin_status = ST_OK;
		fin_dec    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = head_q;
		mem_wdata  = q.item.value;
		mem_raddr  = head_q;
		emit       = 1'b0;
		e_status   = ST_OK;
		e_element  = '0;
		e_last     = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (q.valid && out_free) begin
					pop   = 1'b1;
					idx_d = '0;
					case (q.item.op)
						OP_PUSH_BACK: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = phys_idx(head_q, OFS_W'(count_q));
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_PUSH_FRONT: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								head_d    = prev_idx(head_q);
								mem_we    = 1'b1;
								mem_waddr = head_d;
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_REMOVE: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_NO_MATCH;
							end
						end
						OP_READ_OUT: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				// compare entry idx while the next one is fetched
				mem_raddr = phys_idx(head_q, OFS_W'(idx_q) + OFS_W'(1));
				if (idx_last) begin
					fin_load   = 1'b1;
					fin_status = hit ? ST_OK : ST_NO_MATCH;
					fin_dec    = hit;
				end else if (!hit) begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			BK_SHIFT: begin
				// close the gap: entry idx+1 moves down to idx
				mem_we    = 1'b1;
				mem_waddr = phys_idx(head_q, OFS_W'(idx_q));
				mem_wdata = rdata_q;
				mem_raddr = phys_idx(head_q, OFS_W'(idx_q) + OFS_W'(2));
				if (shift_last) begin
					fin_load   = 1'b1;
					fin_status = ST_OK;
					fin_dec    = 1'b1;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			BK_READ: begin
				if (out_free) begin
					emit      = 1'b1;
					e_element = rdata_q;
					e_last    = idx_last;
					idx_d     = idx_q + IDX_W'(1);
					mem_raddr = phys_idx(head_q, OFS_W'(idx_q) + OFS_W'(1));
				end else begin
					mem_raddr = phys_idx(head_q, OFS_W'(idx_q));
				end
			end
			BK_FIN: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = fin_status_q;
					if (fin_dec_q) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			fin_status_q <= ST_OK;
			fin_dec_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (fin_load) begin
				fin_status_q <= fin_status;
				fin_dec_q    <= fin_dec;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q <= q.item.value;
		end
		if (emit) begin
			rsp_status_q  <= e_status;
			rsp_element_q <= e_element;
			rsp_last_q    <= e_last;
			rsp_occ_q     <= to_occ(count_d);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.element   = rsp_element_q;
	assign rsp.last      = rsp_last_q;
	assign rsp.occupancy = rsp_occ_q;

endmodule

// ----- design/bounded_ordered_list_core.sv -----
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed words kept in a circular store with one read and
// one write port, a head pointer and a count; the list is empty after reset. Each req item
// carries one operation and gives one rsp item, except a read out of a non-empty list,
// which gives one rsp per entry front to back with last set on the final one. A two-entry
// queue separates the front, which takes and decodes requests, from the back, which runs
// them. Push back and push front finish in the back's idle state. Read out walks the
// entries front to back. Remove compares one entry at a time until the match, then moves
// each later entry down to close the gap, then reports. The store's single read port is
// walked one entry per cycle; a stalled rsp side holds the back in place.
module bounded_ordered_list_core (
	input  logic      clk,
	input  logic      arst_n,
	bol_req_if.sink   req,
	bol_rsp_if.source rsp
);
	import bol_pkg::*;

	queue_t q;
	logic   pop;

	bol_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q      (q),
		.pop    (pop)
	);

	bol_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.pop    (pop),
		.rsp    (rsp)
	);

`ifndef ASSERT_OFF
	// back only takes from the queue when something is there
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q.valid)
		else $error("pop with empty queue");

	// a queued item stays until the back takes it
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q.valid && !pop |=> q.valid)
		else $error("queued item lost");

	// only read out results carry an entry; error results end the item
	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.element == '0 && rsp.last)
		else $error("error result with element or without last");
`endif

endmodule
